// ----- hw/rtl/clps_pkg.sv -----
// Shared types and constants for the clipped line pixel stepper.
// No dependencies; imported by every module of the block.
package clps_pkg;

  localparam int COORD_BITS  = 16;
  localparam int SIZE_BITS   = 14;
  localparam int PITCH_BITS  = 16;
  localparam int OFFSET_BITS = 29;
  localparam int COLOUR_BITS = 32;

  // Walk arithmetic widths
  localparam int SPAN_BITS = COORD_BITS + 1;  // |dx|
  localparam int NSPY_BITS = COORD_BITS + 2;  // -|dy|
  localparam int ERR_BITS  = COORD_BITS + 3;  // error term

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH     = 2'd2;

  localparam logic [SIZE_BITS-1:0]  RESET_WIDTH  = 14'd640;
  localparam logic [SIZE_BITS-1:0]  RESET_HEIGHT = 14'd480;
  localparam logic [PITCH_BITS-1:0] RESET_PITCH  = 16'd2560;

  typedef struct packed {
    logic                          operation;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
    logic        [COLOUR_BITS-1:0] line_colour;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic                          inside_res;
    logic        [OFFSET_BITS-1:0] byte_offset;
    logic        [COLOUR_BITS-1:0] pixel_value;
    logic                          last;
  } out_item_t;

  // One walked point, handed from the front part to the back part
  typedef struct packed {
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic        [COLOUR_BITS-1:0] colour;
    logic                          last;
  } pt_t;

  // Screen geometry as seen by the back part
  typedef struct packed {
    logic [SIZE_BITS-1:0]  width;
    logic [SIZE_BITS-1:0]  height;
    logic [PITCH_BITS-1:0] pitch;
  } geom_t;

endpackage

// ----- hw/rtl/clps_front.sv -----
// Front part: takes start and tick items and runs the Bresenham walk.
// Emits one pt_t per tick on an active line. Depends on clps_pkg.
module clps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  clps_pkg::in_item_t item,
  output logic              pt_push,
  output clps_pkg::pt_t     pt
);
  import clps_pkg::*;

  logic                         active;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, goal_x, goal_y;
  logic                         x_backwards, y_backwards;
  logic        [SPAN_BITS-1:0]  span_x;
  logic signed [NSPY_BITS-1:0]  neg_span_y;
  logic signed [ERR_BITS-1:0]   error_term;
  logic        [COLOUR_BITS-1:0] held_colour;

  // start decode
  logic signed [SPAN_BITS-1:0] dx, dy;
  logic        [SPAN_BITS-1:0] abs_dx, abs_dy;
  logic signed [NSPY_BITS-1:0] nsy_load;
  logic signed [ERR_BITS-1:0]  err_load;

  // step
  logic                        done;
  logic signed [ERR_BITS:0]    doubled;
  logic                        step_x, step_y;
  logic signed [ERR_BITS-1:0]  err_next;
  logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next;

  always_comb begin
    dx       = SPAN_BITS'(item.x_end) - SPAN_BITS'(item.x_start);
    dy       = SPAN_BITS'(item.y_end) - SPAN_BITS'(item.y_start);
    abs_dx   = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
    abs_dy   = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);
    nsy_load = -$signed({1'b0, abs_dy});
    err_load = $signed(ERR_BITS'(abs_dx)) + ERR_BITS'(nsy_load);
  end

  always_comb begin
    done    = (cur_x == goal_x) && (cur_y == goal_y);
    doubled = {error_term, 1'b0};
    step_x  = doubled >= (ERR_BITS+1)'(neg_span_y);
    step_y  = doubled <= $signed((ERR_BITS+1)'(span_x));
    err_next = error_term
             + (step_x ? ERR_BITS'(neg_span_y) : '0)
             + (step_y ? $signed(ERR_BITS'(span_x)) : '0);
    // +1 or -1 by sign-filling the step
    cur_x_next = step_x ? cur_x + $signed({{(COORD_BITS-1){x_backwards}}, 1'b1}) : cur_x;
    cur_y_next = step_y ? cur_y + $signed({{(COORD_BITS-1){y_backwards}}, 1'b1}) : cur_y;
  end

  assign pt_push   = accept && (item.operation == OP_TICK) && active;
  assign pt.x      = cur_x;
  assign pt.y      = cur_y;
  assign pt.colour = held_colour;
  assign pt.last   = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept && item.operation == OP_START) begin
      active <= 1'b1;
    end else if (pt_push && done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.operation == OP_START) begin
      cur_x       <= item.x_start;
      cur_y       <= item.y_start;
      goal_x      <= item.x_end;
      goal_y      <= item.y_end;
      held_colour <= item.line_colour;
      x_backwards <= !(item.x_start < item.x_end);
      y_backwards <= !(item.y_start < item.y_end);
      span_x      <= abs_dx;
      neg_span_y  <= nsy_load;
      error_term  <= err_load;
    end else if (pt_push && !done) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    pt_push && pt.last |=> !active)
    else $error("line still active after its last point");
  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    pt_push && !pt.last |=> (cur_x != $past(cur_x)) || (cur_y != $past(cur_y)))
    else $error("walk step did not move the point");
`endif

endmodule

// ----- hw/rtl/clps_queue.sv -----
// Short register queue of walked points between front and back parts.
// Depends on clps_pkg for pt_t.
module clps_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  clps_pkg::pt_t wr_data,
  input  logic          rd,
  output clps_pkg::pt_t rd_data,
  output logic          valid,
  output logic          full
);
  import clps_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pt_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign valid   = count != '0;
  assign full    = count == CNT_W'(DEPTH);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr)
    else $error("write into full point queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !valid |-> !rd)
    else $error("read from empty point queue");
`endif

endmodule

// ----- hw/rtl/clps_back.sv -----
// Back part: clip test and byte offset for each point, two register stages,
// the second being the result register. Depends on clps_pkg.
module clps_back (
  input  logic               clk,
  input  logic               rst,
  input  clps_pkg::geom_t    geom,
  input  logic               in_valid,
  input  clps_pkg::pt_t      in_pt,
  output logic               in_take,
  input  logic               pop,
  output logic               empty,
  output clps_pkg::out_item_t out_item
);
  import clps_pkg::*;

  // stage A: clip test and y*pitch
  logic                   a_vld;
  pt_t                    a_pt;
  logic                   a_inside;
  logic [OFFSET_BITS-1:0] a_prod;

  // stage B: result register
  logic      b_vld;
  out_item_t b_item;

  logic                          a_ready, b_ready;
  logic                          on_screen;
  logic [2*COORD_BITS-1:0]       prod_full;
  logic [OFFSET_BITS-1:0]        x_bytes;

  assign b_ready = !b_vld || pop;
  assign a_ready = !a_vld || b_ready;
  assign in_take = in_valid && a_ready;
  assign empty   = !b_vld;
  assign out_item = b_item;

  always_comb begin
    on_screen = !in_pt.x[COORD_BITS-1] && !in_pt.y[COORD_BITS-1]
             && (in_pt.x[COORD_BITS-2:0] < (COORD_BITS-1)'(geom.width))
             && (in_pt.y[COORD_BITS-2:0] < (COORD_BITS-1)'(geom.height));
    prod_full = $unsigned(in_pt.y) * (2*COORD_BITS)'(geom.pitch);
    x_bytes   = OFFSET_BITS'({a_pt.x[COORD_BITS-2:0], 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld <= in_valid;
      end
      if (b_ready) begin
        b_vld <= a_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_pt     <= in_pt;
      a_inside <= on_screen;
      a_prod   <= prod_full[OFFSET_BITS-1:0];
    end
    if (b_ready && a_vld) begin
      b_item.point_x     <= a_pt.x;
      b_item.point_y     <= a_pt.y;
      b_item.inside_res  <= a_inside;
      b_item.byte_offset <= a_inside ? a_prod + x_bytes : '0;
      b_item.pixel_value <= a_pt.colour;
      b_item.last        <= a_pt.last;
    end
  end

`ifndef SYNTHESIS
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    b_vld && !b_item.inside_res |-> b_item.byte_offset == '0)
    else $error("clipped point with nonzero offset");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    b_vld && !pop |=> b_vld && $stable(b_item))
    else $error("waiting result changed or dropped");
`endif

endmodule

// ----- hw/rtl/clipped_line_pixel_stepper_unit.sv -----
// A tick's point passes through the point queue, stage A and the result register before it shows.
// Throughput: one item per cycle, start or tick, while the point queue has room.
// Rate is set by the walk step in the front part, computed combinationally for each accepted tick.
// Reset (rst, synchronous): no line active, queue and pipeline empty,
// geometry back to 640 x 480 with a 2560-byte pitch.
module clipped_line_pixel_stepper_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // item side
  input  logic                              push,
  output logic                              full,
  input  clps_pkg::in_item_t                in_item,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output clps_pkg::out_item_t               out_item,
  // configuration
  input  logic                              cfg_we,
  input  logic [clps_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [clps_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import clps_pkg::*;

  // Geometry registers; the user must write them only while the block is idle
  // (the block itself does not enforce this), so the back part may read them directly.
  geom_t geom;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.width  <= RESET_WIDTH;
      geom.height <= RESET_HEIGHT;
      geom.pitch  <= RESET_PITCH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  geom.width  <= cfg_wdata[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: geom.height <= cfg_wdata[SIZE_BITS-1:0];
        REG_ROW_PITCH:     geom.pitch  <= cfg_wdata[PITCH_BITS-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Front part: every item is taken while the queue has room, even a tick
  // that makes no point; result stalls reach the front only once they have
  // backed up through the back part and filled the queue.
  logic accept;
  logic pt_push;
  pt_t  front_pt;

  assign accept = push && !full;

  clps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (in_item),
    .pt_push (pt_push),
    .pt      (front_pt)
  );

  // Point queue decouples the walk from result stalls.
  logic q_valid;
  logic q_take;
  pt_t  q_pt;

  clps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (pt_push),
    .wr_data (front_pt),
    .rd      (q_take),
    .rd_data (q_pt),
    .valid   (q_valid),
    .full    (full)
  );

  // Back part: clip, offset, result register.
  clps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .in_valid (q_valid),
    .in_pt    (q_pt),
    .in_take  (q_take),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
